### sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg: shared types, codes and byte classes for the token scanner
// Holds the result record, the scan-mode encoding, the kind and status codes
// and the character-class functions used by the lexer stage.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int DEFAULT_LENGTH_BITS = 16;
  localparam int LEN_OUT_BITS        = 16;
  localparam int FIFO_DEPTH          = 8;
  localparam int FIFO_AW             = $clog2(FIFO_DEPTH);

  // token kinds
  localparam logic [2:0] KIND_NAME = 3'd0;
  localparam logic [2:0] KIND_LIT  = 3'd1;
  localparam logic [2:0] KIND_NUM  = 3'd2;
  localparam logic [2:0] KIND_STR  = 3'd3;
  localparam logic [2:0] KIND_CMT  = 3'd4;
  localparam logic [2:0] KIND_BOOL = 3'd5;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONGRAPH = 2'd1;
  localparam logic [1:0] ST_STRAY    = 2'd2;

  // input op
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // bytes with a meaning of their own
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_NAME = 6'b000010,
    MODE_LIT  = 6'b000100,
    MODE_NUM  = 6'b001000,
    MODE_STR  = 6'b010000,
    MODE_CMT  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [7:0]              tbyte;
    logic                    is_end;
    logic [LEN_OUT_BITS-1:0] len;
    logic                    bval;
    logic [1:0]              status;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h09 || b == 8'h0A || b == 8'h0C || b == 8'h0D || b == CH_SPACE;
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return b == CH_LPAREN || b == CH_RPAREN || b == CH_LT || b == CH_GT ||
           b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_SLASH || b == CH_PERCENT;
  endfunction

  function automatic logic is_num_start(input logic [7:0] b);
    return b == 8'h2B || b == 8'h2D || b == 8'h2E || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic is_graphic(input logic [7:0] b);
    return b > CH_SPACE && b < CH_DEL;
  endfunction

  function automatic logic [7:0] true_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "t";
      2'd1:    c = "r";
      2'd2:    c = "u";
      default: c = "e";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "f";
      3'd1:    c = "a";
      3'd2:    c = "l";
      3'd3:    c = "s";
      3'd4:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### sv/pst_lexer.sv
// ----------------------------------------------------------------------------
// pst_lexer: input register and per-byte scan step
// Registers the accepted item, then classifies the byte against the scan
// mode and emits up to two results per item into the result queue.
// ----------------------------------------------------------------------------
module pst_lexer
  import pst_pkg::*;
#(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  output push_t      push_o,
  output logic       busy_o
);

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

  logic                   stg_v_r;
  logic                   stg_op_r;
  logic [7:0]             stg_byte_r;
  mode_t                  mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic                   tok_r, tok_nxt;
  logic                   fok_r, fok_nxt;

  logic [31:0]            cnt32;
  logic [7:0]             b;
  res_t                   fin_res, app_res, st_res;
  logic                   tok_app, fok_app;
  logic [LENGTH_BITS-1:0] cnt_app;
  mode_t                  st_mode;
  logic                   st_emit;
  logic [LENGTH_BITS-1:0] st_cnt;
  logic                   st_tok, st_fok;
  push_t                  push;

  function automatic logic [2:0] kind_of(input mode_t m);
    logic [2:0] k;
    unique case (m)
      MODE_LIT: k = KIND_LIT;
      MODE_NUM: k = KIND_NUM;
      MODE_STR: k = KIND_STR;
      MODE_CMT: k = KIND_CMT;
      default:  k = KIND_NAME;
    endcase
    return k;
  endfunction

  assign cnt32 = 32'(cnt_r);
  assign b     = stg_byte_r;

  // closing result of the open token
  always_comb begin
    fin_res        = '0;
    fin_res.is_end = 1'b1;
    fin_res.kind   = kind_of(mode_r);
    fin_res.len    = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
    if (mode_r == MODE_NAME && cnt32 == 32'd4 && tok_r) begin
      fin_res.kind = KIND_BOOL;
      fin_res.bval = 1'b1;
    end else if (mode_r == MODE_NAME && cnt32 == 32'd5 && fok_r) begin
      fin_res.kind = KIND_BOOL;
    end
  end

  // value byte added to the open token
  always_comb begin
    app_res       = '0;
    app_res.kind  = kind_of(mode_r);
    app_res.tbyte = b;
    tok_app = tok_r && (cnt32 < 32'd4) && (true_char(cnt32[1:0]) == b);
    fok_app = fok_r && (cnt32 < 32'd5) && (false_char(cnt32[2:0]) == b);
    cnt_app = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_ONE;
  end

  // byte seen between tokens
  always_comb begin
    st_mode = MODE_IDLE;
    st_emit = 1'b0;
    st_res  = '0;
    st_cnt  = '0;
    st_tok  = 1'b1;
    st_fok  = 1'b1;
    st_res.tbyte = b;
    if (is_ws(b)) begin
      st_mode = MODE_IDLE;
    end else if (b == CH_LPAREN) begin
      st_mode = MODE_STR;
    end else if (b == CH_PERCENT) begin
      st_mode = MODE_CMT;
    end else if (b == CH_SLASH) begin
      st_mode = MODE_LIT;
    end else if (b == CH_RPAREN || b == CH_GT) begin
      st_emit       = 1'b1;
      st_res.kind   = KIND_NAME;
      st_res.status = ST_STRAY;
    end else if (is_delim(b)) begin
      st_mode = MODE_IDLE;
    end else if (is_num_start(b) || is_graphic(b)) begin
      st_mode     = is_num_start(b) ? MODE_NUM : MODE_NAME;
      st_emit     = 1'b1;
      st_res.kind = is_num_start(b) ? KIND_NUM : KIND_NAME;
      st_cnt      = CNT_ONE;
      st_tok      = (b == true_char(2'd0));
      st_fok      = (b == false_char(3'd0));
    end else begin
      st_emit       = 1'b1;
      st_res.kind   = KIND_NAME;
      st_res.status = ST_NONGRAPH;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    tok_nxt  = tok_r;
    fok_nxt  = fok_r;
    push     = '0;
    if (stg_v_r) begin
      if (stg_op_r == OP_END) begin
        if (mode_r == MODE_NAME || mode_r == MODE_LIT || mode_r == MODE_NUM ||
            mode_r == MODE_STR || mode_r == MODE_CMT) begin
          push.r0 = fin_res;
          push.n  = 2'd1;
        end
        mode_nxt = MODE_IDLE;
        cnt_nxt  = '0;
        tok_nxt  = 1'b1;
        fok_nxt  = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_NAME, MODE_LIT, MODE_NUM: begin
            if (is_ws(b) || is_delim(b)) begin
              // whitespace or delimiter closes the token, then is scanned as a fresh byte
              push.r0  = fin_res;
              push.r1  = st_res;
              push.n   = st_emit ? 2'd2 : 2'd1;
              mode_nxt = st_mode;
              cnt_nxt  = st_cnt;
              tok_nxt  = st_tok;
              fok_nxt  = st_fok;
            end else begin
              push.r0 = app_res;
              push.n  = 2'd1;
              cnt_nxt = cnt_app;
              tok_nxt = tok_app;
              fok_nxt = fok_app;
            end
          end
          MODE_STR, MODE_CMT: begin
            if ((mode_r == MODE_STR && b == CH_RPAREN) ||
                (mode_r == MODE_CMT && b == CH_NL)) begin
              push.r0  = fin_res;
              push.n   = 2'd1;
              mode_nxt = MODE_IDLE;
              cnt_nxt  = '0;
              tok_nxt  = 1'b1;
              fok_nxt  = 1'b1;
            end else begin
              push.r0 = app_res;
              push.n  = 2'd1;
              cnt_nxt = cnt_app;
              tok_nxt = tok_app;
              fok_nxt = fok_app;
            end
          end
          default: begin
            push.r0  = st_res;
            push.n   = st_emit ? 2'd1 : 2'd0;
            mode_nxt = st_mode;
            cnt_nxt  = st_cnt;
            tok_nxt  = st_tok;
            fok_nxt  = st_fok;
          end
        endcase
      end
      if (push.n == 2'd1) begin
        push.r0.last = 1'b1;
      end
      if (push.n == 2'd2) begin
        push.r1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      mode_r  <= MODE_IDLE;
      cnt_r   <= '0;
      tok_r   <= 1'b1;
      fok_r   <= 1'b1;
    end else begin
      stg_v_r <= in_fire;
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      tok_r   <= tok_nxt;
      fok_r   <= fok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_op_r   <= in_op;
      stg_byte_r <= in_byte;
    end
  end

  assign push_o = push;
  assign busy_o = stg_v_r;

endmodule

### sv/pst_fifo.sv
// ----------------------------------------------------------------------------
// pst_fifo: result queue
// Small register queue that takes up to two results a cycle from the lexer
// and hands one result a cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module pst_fifo
  import pst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push_i,
  input  logic             pop_i,
  output res_t             head_o,
  output logic [FIFO_AW:0] fill_o
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   fill_r, fill_nxt;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_AW'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_i.n);
  assign rd_ptr_nxt = pop_i ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
  assign fill_nxt   = fill_r + (FIFO_AW+1)'(push_i.n) - (FIFO_AW+1)'(pop_i);

  always_ff @(posedge clk) begin
    if (push_i.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign head_o = mem_r[rd_ptr_r];
  assign fill_o = fill_r;

endmodule

### sv/postscript_token_scanner.sv
// ----------------------------------------------------------------------------
// postscript_token_scanner: byte-stream token scanner
// Splits a byte stream into name, literal name, number, string and comment
// tokens, tags every value byte with its kind and closes each token with an
// end result carrying kind and saturated length.
//
// in_* channel: one item per byte (in_tuser = 0) or an end-of-stream marker
// (in_tuser = 1). out_* channel: zero, one or two results per input item,
// out_tlast set on the last result of each input item.
// An accepted item is registered in the input stage, its results in the
// result queue. Throughput: one item per cycle while in_tready is high; an
// item that closes a token and is a stray ) or > puts out two results, which
// drain at one per cycle through the 8-entry queue while out_tready is high.
// in_tready depends only on registered queue fill and the input stage: it
// drops unless the queue has room for two results each from the staged and
// offered items; a stalled receiver fills the queue and then holds off the
// sender, nothing lost. Reset puts the scanner idle between tokens, queue empty.
// ----------------------------------------------------------------------------
module postscript_token_scanner
  import pst_pkg::*;
#(
  parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_in
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // token_byte, token_length
  output logic [6:0]  out_tuser,  // token_kind, is_token_end, bool_value, status
  output logic        out_tlast   // last_of_run
);

  logic             in_fire;
  logic             pop;
  push_t            push;
  logic             busy;
  res_t             head;
  logic [FIFO_AW:0] fill;
  logic [FIFO_AW+1:0] room_need;

  // room for the item in the stage plus the one now offered
  assign room_need = (FIFO_AW+2)'(fill) + (busy ? (FIFO_AW+2)'(2) : '0);
  assign in_tready = room_need <= (FIFO_AW+2)'(FIFO_DEPTH - 2);
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  pst_lexer #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_op  (in_tuser),
    .in_byte(in_tdata),
    .push_o (push),
    .busy_o (busy)
  );

  pst_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push_i(push),
    .pop_i (pop),
    .head_o(head),
    .fill_o(fill)
  );

  assign out_tvalid = fill != '0;
  assign out_tdata  = {head.len, head.tbyte};
  assign out_tuser  = {head.status, head.bval, head.is_end, head.kind};
  assign out_tlast  = head.last;

  // queue never overflows
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  // results only come from an item held in the stage
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> busy)
    else $error("result pushed without an item");

  // a pair of results is always a token end followed by the delimiter's result
  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.r0.is_end && !push.r0.last && push.r1.last))
    else $error("malformed result pair");

endmodule
